// ----- src/tcc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the text console cursor engine.
// Used by every module of the block; depends on nothing.

package tcc_pkg;

	localparam logic [7:0]  ATTR_NORMAL   = 8'h07;
	localparam logic [15:0] BLANK_FILL    = 16'h0720;
	localparam logic [7:0]  CHAR_NEWLINE  = 8'd10;
	localparam logic [7:0]  CHAR_TAB      = 8'd9;
	localparam logic [8:0]  TAB_STEP      = 9'd8;
	localparam logic [8:0]  TAB_MASK      = ~(TAB_STEP - 9'd1);
	localparam logic [7:0]  COLUMNS_RESET = 8'd80;
	localparam logic [7:0]  ROWS_RESET    = 8'd25;

	// Register indexes of the configuration port.
	localparam logic CFG_COLUMNS = 1'b0;
	localparam logic CFG_ROWS    = 1'b1;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] col;
		logic [7:0] row;
	} cursor_t;

	// All results caused by one character; the cursor result is always present.
	typedef struct packed {
		logic        has_write;
		logic        has_scroll;
		logic [15:0] write_index;
		logic [15:0] write_word;
		logic [15:0] cursor_index;
	} res_set_t;

endpackage

// ----- src/tcc_step.sv -----
`timescale 1ns / 1ps
// Cursor update logic for one character: clamp, move, wrap, scroll, address.
// Depends on tcc_pkg.

module tcc_step (
	input  logic [7:0]       char_code,
	input  tcc_pkg::cursor_t cur,
	input  logic [7:0]       columns,
	input  logic [7:0]       rows,
	output tcc_pkg::res_set_t res,
	output tcc_pkg::cursor_t  cur_next
);

	logic [7:0]  ncol;
	logic [7:0]  nrow;
	logic [7:0]  col_c;
	logic [7:0]  row_c;
	logic [8:0]  col_m;
	logic [8:0]  row_m;
	logic [8:0]  col_w;
	logic [8:0]  row_w;
	logic [7:0]  col_f;
	logic [7:0]  row_f;
	logic        printable;
	logic [15:0] write_prod;
	logic [15:0] cursor_prod;

	always_comb begin
		ncol = (columns == 8'd0) ? 8'd1 : columns;
		nrow = (rows == 8'd0) ? 8'd1 : rows;
		// pull a stale cursor back inside a shrunken screen
		col_c = (cur.col >= ncol) ? ncol - 8'd1 : cur.col;
		row_c = (cur.row >= nrow) ? nrow - 8'd1 : cur.row;

		printable = 1'b0;
		row_m = {1'b0, row_c};
		case (char_code)
			tcc_pkg::CHAR_NEWLINE: begin
				col_m = 9'd0;
				row_m = {1'b0, row_c} + 9'd1;
			end
			tcc_pkg::CHAR_TAB: begin
				col_m = ({1'b0, col_c} + tcc_pkg::TAB_STEP) & tcc_pkg::TAB_MASK;
			end
			default: begin
				printable = 1'b1;
				col_m = {1'b0, col_c} + 9'd1;
			end
		endcase

		// wrap past the last column
		if (col_m >= {1'b0, ncol}) begin
			col_w = 9'd0;
			row_w = row_m + 9'd1;
		end else begin
			col_w = col_m;
			row_w = row_m;
		end

		res.has_scroll = (row_w >= {1'b0, nrow});
		row_f = res.has_scroll ? nrow - 8'd1 : row_w[7:0];
		col_f = col_w[7:0];

		write_prod  = {8'd0, row_c} * {8'd0, ncol};
		cursor_prod = {8'd0, row_f} * {8'd0, ncol};

		res.has_write    = printable;
		res.write_index  = write_prod + {8'd0, col_c};
		res.write_word   = {tcc_pkg::ATTR_NORMAL, char_code};
		res.cursor_index = cursor_prod + {8'd0, col_f};

		cur_next.col = col_f;
		cur_next.row = row_f;
	end

endmodule

// ----- src/tcc_out_queue.sv -----
`timescale 1ns / 1ps
// Result register for one character's set of results, drained one beat a cycle while m_tready is high.
// Depends on tcc_pkg.

module tcc_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tcc_pkg::res_set_t res,
	output logic              load_ok,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // cell_index[15:0], cell_word[31:16]
	output logic [1:0]        m_tuser,   // kind[1:0]
	output logic              m_tlast
);

	logic              write_q;
	logic              scroll_q;
	logic              cursor_q;
	tcc_pkg::res_set_t res_q;
	tcc_pkg::kind_t    kind;
	logic [15:0]       index;
	logic [15:0]       word;
	logic              take;

	assign m_tvalid = write_q | scroll_q | cursor_q;
	assign take     = m_tvalid & m_tready;
	assign load_ok  = !m_tvalid || (take && !write_q && !scroll_q);

	always_comb begin
		if (write_q) begin
			kind  = tcc_pkg::KIND_WRITE;
			index = res_q.write_index;
			word  = res_q.write_word;
		end else if (scroll_q) begin
			kind  = tcc_pkg::KIND_SCROLL;
			index = 16'd0;
			word  = tcc_pkg::BLANK_FILL;
		end else begin
			kind  = tcc_pkg::KIND_CURSOR;
			index = res_q.cursor_index;
			word  = 16'd0;
		end
	end

	assign m_tdata = {word, index};
	assign m_tuser = kind;
	assign m_tlast = !write_q && !scroll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_q  <= 1'b0;
			scroll_q <= 1'b0;
			cursor_q <= 1'b0;
		end else if (load) begin
			write_q  <= res.has_write;
			scroll_q <= res.has_scroll;
			cursor_q <= 1'b1;
		end else if (take) begin
			if (write_q) begin
				write_q <= 1'b0;
			end else if (scroll_q) begin
				scroll_q <= 1'b0;
			end else begin
				cursor_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- src/text_console_cursor_engine.sv -----
`timescale 1ns / 1ps
// Text console cursor engine: character beats in, cell write / scroll / cursor beats out.
// The input register stages each character, then the result register holds its result beats.
// Each character causes one to three result beats; the result register drains one beat
//   per cycle while m_tready is high and loads the next character as its final beat is taken.
// Reset: arst_n clears the cursor to row 0 column 0, columns to 80, rows to 25,
//   and empties the input and result registers. Depends on tcc_pkg, tcc_step, tcc_out_queue.

module text_console_cursor_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cell_index[15:0], cell_word[31:16]
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic [7:0]        columns_q;
	logic [7:0]        rows_q;
	tcc_pkg::cursor_t  cursor_q;
	tcc_pkg::cursor_t  cursor_next;
	tcc_pkg::res_set_t res;
	logic              load_ok;
	logic              advance;

	// Move the staged character into the result register once the previous
	// set is gone or is handing over its final beat this cycle.
	assign advance  = valid_s1 & load_ok;
	// Take a new beat whenever the input register is empty or emptying.
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	// Configuration registers; the user must write them only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= tcc_pkg::COLUMNS_RESET;
			rows_q    <= tcc_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tcc_pkg::CFG_COLUMNS: columns_q <= cfg_wdata;
				tcc_pkg::CFG_ROWS:    rows_q    <= cfg_wdata;
				default:              rows_q    <= rows_q;
			endcase
		end
	end

	// Cursor commits together with the result set, so the next staged
	// character always sees the position left by the one before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (advance) begin
			cursor_q <= cursor_next;
		end
	end

	tcc_step u_step (
		.char_code (char_s1),
		.cur       (cursor_q),
		.columns   (columns_q),
		.rows      (rows_q),
		.res       (res),
		.cur_next  (cursor_next)
	);

	tcc_out_queue u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- src/tcc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the text console cursor engine, bound to the top level.
// Depends on tcc_pkg and text_console_cursor_engine.

module tcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

	// the cursor beat, and only it, closes a character's results
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == tcc_pkg::KIND_CURSOR)))
		else $error("tlast does not match cursor kind");

	a_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == tcc_pkg::KIND_SCROLL |->
			m_tdata == {tcc_pkg::BLANK_FILL, 16'd0})
		else $error("bad scroll beat");

	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == tcc_pkg::KIND_WRITE |->
			m_tdata[31:24] == tcc_pkg::ATTR_NORMAL &&
			m_tdata[23:16] != tcc_pkg::CHAR_NEWLINE &&
			m_tdata[23:16] != tcc_pkg::CHAR_TAB)
		else $error("bad cell write beat");

	// a written cell is followed by scroll or cursor, never another write
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == tcc_pkg::KIND_WRITE |=>
			m_tvalid && m_tuser != tcc_pkg::KIND_WRITE)
		else $error("write not followed by rest of its results");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (.*);
